/* hdl/cec_pkg.sv */
// ============================================================================
// cec_pkg: shared types and constants for the calendar epoch converter
// Holds the operation codes, calendar constants and the item structs that
// pass between the pipeline stages.
// ============================================================================
`default_nettype none

package cec_pkg;

    localparam logic OP_TO_CAL = 1'b0;
    localparam logic OP_TO_EPOCH = 1'b1;

    localparam logic [31:0] EPOCH_2000 = 32'd946684800;
    localparam logic [31:0] EPOCH_2100 = 32'd4102444800;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;

    // Register stages of each conversion path.
    localparam int PIPE_STAGES = 5;

    typedef struct packed {
        logic       op;
        logic [31:0] epoch_in;
        logic [6:0] year_in;
        logic [3:0] month_in;
        logic [4:0] day_in;
        logic [4:0] hour_in;
        logic [5:0] minute_in;
        logic [5:0] second_in;
    } cec_in_t;

    typedef struct packed {
        logic [31:0] epoch_out;
        logic [6:0] year_out;
        logic [3:0] month_out;
        logic [4:0] day_out;
        logic [4:0] hour_out;
        logic [5:0] minute_out;
        logic [5:0] second_out;
        logic [2:0] weekday;
        logic       out_of_range;
    } cec_out_t;

    // Days before the first of a month in a common year, month 1..12.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] r;
        begin
            case (m)
                4'd1: r = 9'd0;
                4'd2: r = 9'd31;
                4'd3: r = 9'd59;
                4'd4: r = 9'd90;
                4'd5: r = 9'd120;
                4'd6: r = 9'd151;
                4'd7: r = 9'd181;
                4'd8: r = 9'd212;
                4'd9: r = 9'd243;
                4'd10: r = 9'd273;
                4'd11: r = 9'd304;
                default: r = 9'd334;
            endcase
            return r;
        end
    endfunction

endpackage

`default_nettype wire

/* hdl/cec_stream_if.sv */
// ============================================================================
// cec_stream_if: valid/ready channel
// Carries one payload per transfer between a source and a sink.
// ============================================================================
`default_nettype none

interface cec_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

/* hdl/cec_to_cal.sv */
// ============================================================================
// cec_to_cal: epoch to calendar stages
// Splits an epoch into time of day, weekday, year, month and day. Each stage
// is registered; the pipeline advances as a whole when the tail is free.
// ============================================================================
`default_nettype none

module cec_to_cal (
    input  wire logic              clk,
    input  wire logic              adv,
    input  wire cec_pkg::cec_in_t  din,
    output cec_pkg::cec_out_t      dout
);
    import cec_pkg::*;

    // Division by a constant is a multiply by a rounded-up reciprocal and a
    // right shift; the quotient is exact over the operand width noted.
    localparam logic [50:0] RECIP_675 = 51'd50903317;   // shift 35, 25-bit operand
    localparam logic [34:0] RECIP_7 = 35'd149797;       // shift 20, 17-bit operand
    localparam logic [31:0] RECIP_1461 = 32'd91868;     // shift 27, 16-bit operand
    localparam logic [29:0] RECIP_15 = 30'd34953;       // shift 19, 15-bit operand
    localparam logic [25:0] RECIP_225 = 26'd9321;       // shift 21, 13-bit operand

    // Stage 1: range check, offset from 2000 and the day number.
    logic [31:0] rel;
    logic [50:0] days_prod;
    logic        oor_c;
    logic [15:0] d1_reg;
    logic [16:0] r1_reg;
    logic        oor1_reg;
    logic [31:0] ep1_reg;

    assign rel = din.epoch_in - EPOCH_2000;
    assign oor_c = (din.epoch_in < EPOCH_2000) || (din.epoch_in >= EPOCH_2100);
    // A day is 128 * 675 seconds: drop the power of two, then divide by 675.
    assign days_prod = 51'(rel[31:7]) * RECIP_675;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d1_reg <= days_prod[50:35];
            r1_reg <= rel[16:0];
            oor1_reg <= oor_c;
            ep1_reg <= din.epoch_in;
        end
    end

    // Stage 2: seconds of the day, weekday and the four-year block.
    logic [16:0] sod_c;
    logic [16:0] wx_c;
    logic [34:0] wq_prod;
    logic [16:0] wq_c;
    logic [2:0]  wd_c;
    logic [31:0] quad_prod;
    logic [16:0] sod2_reg;
    logic [2:0]  w2_reg;
    logic [4:0]  q2_reg;
    logic [15:0] d2_reg;
    logic        oor2_reg;
    logic [31:0] ep2_reg;

    // The seconds of the day fit in 17 bits, so the low bits are enough.
    assign sod_c = r1_reg - 17'(32'(d1_reg) * 32'(SECS_PER_DAY));
    assign wx_c = 17'(d1_reg) + 17'd6;
    assign wq_prod = 35'(wx_c) * RECIP_7;
    assign wq_c = 17'(wq_prod[34:20]);
    assign wd_c = 3'(wx_c - wq_c * 17'd7);
    assign quad_prod = 32'(d1_reg) * RECIP_1461;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sod2_reg <= sod_c;
            w2_reg <= wd_c;
            q2_reg <= quad_prod[31:27];
            d2_reg <= d1_reg;
            oor2_reg <= oor1_reg;
            ep2_reg <= ep1_reg;
        end
    end

    // Stage 3: minutes and hours of the day, day within the four-year block.
    logic [29:0] mins_prod;
    logic [25:0] hr_prod;
    logic [10:0] qrem_c;
    logic [16:0] sod3_reg;
    logic [10:0] mins3_reg;
    logic [4:0]  h3_reg;
    logic [10:0] qrem3_reg;
    logic [4:0]  q3_reg;
    logic [2:0]  w3_reg;
    logic        oor3_reg;
    logic [31:0] ep3_reg;

    // A minute is 4 * 15 seconds and an hour is 16 * 225 seconds.
    assign mins_prod = 30'(sod2_reg[16:2]) * RECIP_15;
    assign hr_prod = 26'(sod2_reg[16:4]) * RECIP_225;
    assign qrem_c = 11'(d2_reg - 16'(q2_reg) * 16'd1461);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            sod3_reg <= sod2_reg;
            mins3_reg <= mins_prod[29:19];
            h3_reg <= hr_prod[25:21];
            qrem3_reg <= qrem_c;
            q3_reg <= q2_reg;
            w3_reg <= w2_reg;
            oor3_reg <= oor2_reg;
            ep3_reg <= ep2_reg;
        end
    end

    // Stage 4: second and minute remainders, year and day of the year.
    logic [5:0] sec_c;
    logic [5:0] min_c;
    logic [1:0] yo_c;
    logic [8:0] doy_c;
    logic [5:0] s4_reg, m4_reg;
    logic [4:0] h4_reg;
    logic [2:0] w4_reg;
    logic [6:0] y4_reg;
    logic [8:0] doy4_reg;
    logic       lp4_reg, oor4_reg;
    logic [31:0] ep4_reg;

    assign sec_c = 6'(sod3_reg - 17'(mins3_reg) * 17'd60);
    assign min_c = 6'(mins3_reg - 11'(h3_reg) * 11'd60);

    // The first year of each block is the leap year.
    always_comb
    begin
        if (qrem3_reg < 11'd366)
        begin
            yo_c = 2'd0;
            doy_c = 9'(qrem3_reg);
        end
        else if (qrem3_reg < 11'd731)
        begin
            yo_c = 2'd1;
            doy_c = 9'(qrem3_reg - 11'd366);
        end
        else if (qrem3_reg < 11'd1096)
        begin
            yo_c = 2'd2;
            doy_c = 9'(qrem3_reg - 11'd731);
        end
        else
        begin
            yo_c = 2'd3;
            doy_c = 9'(qrem3_reg - 11'd1096);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s4_reg <= sec_c;
            m4_reg <= min_c;
            h4_reg <= h3_reg;
            w4_reg <= w3_reg;
            y4_reg <= {q3_reg, yo_c};
            doy4_reg <= doy_c;
            lp4_reg <= (yo_c == 2'd0);
            oor4_reg <= oor3_reg;
            ep4_reg <= ep3_reg;
        end
    end

    // Stage 5: month and day from the day of the year.
    logic [3:0] mo_c;
    logic [8:0] base_c;
    logic [8:0] st;
    cec_out_t   res_c;

    always_comb
    begin
        mo_c = 4'd1;
        for (int i = 2; i <= 12; i++)
        begin
            st = days_before(4'(i)) + ((lp4_reg && i > 2) ? 9'd1 : 9'd0);
            if (doy4_reg >= st)
                mo_c = 4'(i);
        end
        base_c = days_before(mo_c) + ((lp4_reg && mo_c > 4'd2) ? 9'd1 : 9'd0);
    end

    // Out-of-range epochs give a zero result with only the flag set.
    always_comb
    begin
        res_c = '0;
        if (oor4_reg)
        begin
            res_c.out_of_range = 1'b1;
        end
        else
        begin
            res_c.epoch_out = ep4_reg;
            res_c.year_out = y4_reg;
            res_c.month_out = mo_c;
            res_c.day_out = 5'(doy4_reg - base_c + 9'd1);
            res_c.hour_out = h4_reg;
            res_c.minute_out = m4_reg;
            res_c.second_out = s4_reg;
            res_c.weekday = w4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            dout <= res_c;
    end
endmodule

`default_nettype wire

/* hdl/cec_to_epoch.sv */
// ============================================================================
// cec_to_epoch: calendar to epoch stages
// Builds the day count, then the seconds, then the epoch and weekday, and
// carries the result through two more stages to match the other path.
// ============================================================================
`default_nettype none

module cec_to_epoch (
    input  wire logic              clk,
    input  wire logic              adv,
    input  wire cec_pkg::cec_in_t  din,
    output cec_pkg::cec_out_t      dout
);
    import cec_pkg::*;

    // Rounded-up reciprocal of 7 for a 17-bit operand, used with a shift of 20.
    localparam logic [34:0] RECIP_7 = 35'd149797;

    // Stage 1: day count since 2000, plus one.
    logic [3:0] mc;
    logic [31:0] cnt_c;
    cec_in_t f1_reg;
    logic [31:0] c1_reg;

    always_comb
    begin
        mc = din.month_in;
        if (mc < 4'd1)
            mc = 4'd1;
        if (mc > 4'd12)
            mc = 4'd12;
        cnt_c = 32'(din.day_in) + 32'(days_before(mc)) + 32'(din.year_in) * 32'd365
            + ((32'(din.year_in) + 32'd3) >> 2);
        if (mc > 4'd2 && din.year_in[1:0] == 2'd0)
            cnt_c = cnt_c + 32'd1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f1_reg <= din;
            c1_reg <= cnt_c;
        end
    end

    // Stage 2: day seconds, time of day seconds and the weekday quotient.
    logic [16:0] wx_c;
    logic [34:0] wq_prod;
    cec_in_t f2_reg;
    logic [31:0] ds2_reg, tod2_reg;
    logic [16:0] wx2_reg;
    logic [14:0] wq2_reg;

    // The day count stays well below 2^17 for any 7-bit year.
    assign wx_c = 17'(c1_reg) + 17'd5;
    assign wq_prod = 35'(wx_c) * RECIP_7;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f2_reg <= f1_reg;
            ds2_reg <= c1_reg * 32'(SECS_PER_DAY);
            tod2_reg <= 32'(f1_reg.hour_in) * 32'd3600 + 32'(f1_reg.minute_in) * 32'd60
                + 32'(f1_reg.second_in);
            wx2_reg <= wx_c;
            wq2_reg <= wq_prod[34:20];
        end
    end

    // Stage 3: final sum and weekday remainder.
    cec_out_t r3_reg, r4_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r3_reg.epoch_out <= ds2_reg - 32'(SECS_PER_DAY) + tod2_reg + EPOCH_2000;
            r3_reg.year_out <= f2_reg.year_in;
            r3_reg.month_out <= f2_reg.month_in;
            r3_reg.day_out <= f2_reg.day_in;
            r3_reg.hour_out <= f2_reg.hour_in;
            r3_reg.minute_out <= f2_reg.minute_in;
            r3_reg.second_out <= f2_reg.second_in;
            r3_reg.weekday <= 3'(wx2_reg - 17'(wq2_reg) * 17'd7);
            r3_reg.out_of_range <= 1'b0;
        end
    end

    // Stages 4 and 5: delay to the latency of the epoch to calendar path.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r4_reg <= r3_reg;
            dout <= r4_reg;
        end
    end
endmodule

`default_nettype wire

/* hdl/calendar_epoch_converter_top.sv */
// ============================================================================
// calendar_epoch_converter_top: epoch and calendar conversion, 2000 to 2099
// Accepts one item a cycle while the output side takes each finished result.
// The five register stages of both paths set the latency, and the whole
// pipeline holds while a finished result waits for its output transfer.
// Reset clears the stage valid bits only; data registers are not reset.
// ============================================================================
`default_nettype none

module calendar_epoch_converter_top (
    input wire logic clk,
    input wire logic rst_n,
    cec_stream_if.sink   in_ch,
    cec_stream_if.source out_ch
);
    import cec_pkg::*;

    localparam int STAGES = PIPE_STAGES;

    cec_out_t cal_res, ep_res;
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] op_reg;
    logic adv;

    // The whole pipeline moves when the tail is empty or being taken.
    assign adv = !vld_reg[STAGES-1] || out_ch.ready;
    assign in_ch.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[STAGES-2:0], in_ch.valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            op_reg <= {op_reg[STAGES-2:0], in_ch.data.op};
    end

    cec_to_cal u_cal (
        .clk  (clk),
        .adv  (adv),
        .din  (in_ch.data),
        .dout (cal_res)
    );

    cec_to_epoch u_ep (
        .clk (clk),
        .adv (adv),
        .din (in_ch.data),
        .dout(ep_res)
    );

    assign out_ch.valid = vld_reg[STAGES-1];
    assign out_ch.data = (op_reg[STAGES-1] == OP_TO_EPOCH) ? ep_res : cal_res;
endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// ============================================================================
// testbench: self-checking bench for the calendar epoch converter
// Drives epoch and calendar items through the input channel, predicts each
// result with an independent model of the conversion, and compares every
// field of each result in arrival order. Both sides idle at random, and the
// output side holds off once for a long stretch to fill the pipeline.
// ============================================================================
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import cec_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int RANDOM_ITEMS = 1630;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    cec_stream_if #(.payload_t(cec_in_t)) in_ch ();
    cec_stream_if #(.payload_t(cec_out_t)) out_ch ();

    calendar_epoch_converter_top uut (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch.sink),
        .out_ch(out_ch.source)
    );

    cec_out_t expected_dates[$];
    int       mismatches = 0;
    int       cycles = 0;
    bit       long_hold = 1'b0;

    always #5 clk = ~clk;

    // Abort the run if it takes far longer than any correct run could.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Length of month mo (1..12) in a year with or without a leap day.
    function automatic int unsigned month_days(int unsigned mo, bit leap);
        int unsigned n;
        case (mo)
            2: n = leap ? 29 : 28;
            4, 6, 9, 11: n = 30;
            default: n = 31;
        endcase
        return n;
    endfunction

    // Predict the converter result for one input item.
    function automatic cec_out_t convert_date(cec_in_t it);
        cec_out_t    r;
        int unsigned rel, days, yr, mo, ylen, mc, cnt, prior;
        bit          leap;
        logic [31:0] secs;
        r = '0;
        if (it.op == OP_TO_CAL)
        begin
            if (it.epoch_in < EPOCH_2000 || it.epoch_in >= EPOCH_2100)
            begin
                r.out_of_range = 1'b1;
                return r;
            end
            rel = it.epoch_in - EPOCH_2000;
            r.epoch_out = it.epoch_in;
            r.second_out = 6'(rel % 60);
            r.minute_out = 6'((rel / 60) % 60);
            r.hour_out = 5'((rel / 3600) % 24);
            days = rel / 86400;
            r.weekday = 3'((days + 6) % 7);
            yr = 0;
            forever
            begin
                leap = (yr % 4) == 0;
                ylen = leap ? 366 : 365;
                if (days < ylen)
                    break;
                days -= ylen;
                yr++;
            end
            mo = 1;
            while (mo < 12 && days >= month_days(mo, leap))
            begin
                days -= month_days(mo, leap);
                mo++;
            end
            r.year_out = 7'(yr);
            r.month_out = 4'(mo);
            r.day_out = 5'(days + 1);
        end
        else
        begin
            mc = 32'(it.month_in);
            if (mc < 1)
                mc = 1;
            if (mc > 12)
                mc = 12;
            prior = 0;
            for (int unsigned k = 1; k < mc; k++)
                prior += month_days(k, 1'b0);
            cnt = 32'(it.day_in) + prior + 365 * 32'(it.year_in)
                + (32'(it.year_in) + 3) / 4;
            if (mc > 2 && it.year_in % 4 == 0)
                cnt++;
            secs = 32'(cnt) * 32'd86400 - 32'd86400 + 32'(it.hour_in) * 32'd3600
                + 32'(it.minute_in) * 32'd60 + 32'(it.second_in) + EPOCH_2000;
            r.epoch_out = secs;
            r.year_out = it.year_in;
            r.month_out = it.month_in;
            r.day_out = it.day_in;
            r.hour_out = it.hour_in;
            r.minute_out = it.minute_in;
            r.second_out = it.second_in;
            r.weekday = 3'((cnt + 5) % 7);
        end
        return r;
    endfunction

    // Random gap length: mostly short, sometimes long.
    function automatic int gap_len();
        int n;
        if ($urandom_range(0, 3) == 0)
            n = 0;
        else if ($urandom_range(0, 19) == 0)
            n = $urandom_range(10, 40);
        else
            n = $urandom_range(0, 3);
        return n;
    endfunction

    // Fully random input item.
    function automatic cec_in_t random_item();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(cec_in_t)-1:0];
    endfunction

    // Offer one item and hold it until the transfer, then idle a random while if idle_after is set.
    task automatic send_item(cec_in_t it, bit idle_after);
        int n;
        in_ch.data <= it;
        in_ch.valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_dates.push_back(convert_date(it));
        @(negedge clk);
        n = idle_after ? gap_len() : 0;
        if (n > 0)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= random_item();
            repeat (n) @(negedge clk);
        end
    endtask

    function automatic cec_in_t epoch_item(logic [31:0] t);
        cec_in_t it;
        it = random_item();
        it.op = OP_TO_CAL;
        it.epoch_in = t;
        return it;
    endfunction

    function automatic cec_in_t cal_item(int y, int mo, int d, int h, int mi, int s);
        cec_in_t it;
        it = random_item();
        it.op = OP_TO_EPOCH;
        it.year_in = 7'(y);
        it.month_in = 4'(mo);
        it.day_in = 5'(d);
        it.hour_in = 5'(h);
        it.minute_in = 6'(mi);
        it.second_in = 6'(s);
        return it;
    endfunction

    // Range edges, leap boundaries and year ends for epoch to calendar.
    task automatic test_epoch_edges();
        send_item(epoch_item(32'd0), 1'b0);
        send_item(epoch_item(EPOCH_2000 - 1), 1'b1);
        send_item(epoch_item(EPOCH_2000), 1'b0);
        send_item(epoch_item(EPOCH_2000 + 59 * 86400), 1'b1);
        send_item(epoch_item(EPOCH_2000 + 60 * 86400 - 1), 1'b0);
        send_item(epoch_item(EPOCH_2000 + 366 * 86400), 1'b0);
        send_item(epoch_item(EPOCH_2100 - 1), 1'b1);
        send_item(epoch_item(EPOCH_2100), 1'b0);
        send_item(epoch_item(32'hFFFF_FFFF), 1'b0);
    endtask

    // Field extremes and out-of-range calendar fields.
    task automatic test_calendar_edges();
        send_item(cal_item(0, 1, 1, 0, 0, 0), 1'b0);
        send_item(cal_item(99, 12, 31, 23, 59, 59), 1'b1);
        send_item(cal_item(4, 2, 29, 12, 30, 30), 1'b0);
        send_item(cal_item(4, 3, 1, 0, 0, 0), 1'b0);
        send_item(cal_item(5, 0, 0, 24, 0, 0), 1'b1);
        send_item(cal_item(8, 15, 31, 31, 63, 63), 1'b0);
        send_item(cal_item(127, 13, 31, 31, 63, 63), 1'b0);
        send_item(cal_item(100, 2, 1, 0, 0, 0), 1'b1);
        send_item(cal_item(0, 12, 31, 23, 59, 59), 1'b0);
    endtask

    // Random items of both ops, mostly in range, with a long output stall.
    task automatic test_random_mix();
        cec_in_t it;
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == RANDOM_ITEMS / 2)
                long_hold = 1'b1;
            case ($urandom_range(0, 9))
                0: it = epoch_item($urandom);
                1, 2, 3, 4: it = epoch_item($urandom_range(EPOCH_2100 - 1, EPOCH_2000));
                5:
                begin
                    it = random_item();
                    it.op = OP_TO_EPOCH;
                end
                default:
                    it = cal_item($urandom_range(0, 99), $urandom_range(1, 12),
                        $urandom_range(1, 28), $urandom_range(0, 23),
                        $urandom_range(0, 59), $urandom_range(0, 59));
            endcase
            send_item(it, $urandom_range(0, 4) != 0 && i % 200 > 40);
        end
    endtask

    // Output side: random backpressure plus one long hold-off.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (long_hold)
            begin
                long_hold = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (300) @(negedge clk);
            end
            if ((cycles / 500) % 3 == 0)
                out_ch.ready <= 1'b1;
            else
                out_ch.ready <= $urandom_range(0, 3) != 0 || $urandom_range(0, 20) == 0;
        end
    end

    // Compare each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        cec_out_t want, got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = out_ch.data;
            if (expected_dates.size() == 0)
            begin
                $error("result with no prediction pending");
                mismatches++;
            end
            else
            begin
                want = expected_dates.pop_front();
                if (got.epoch_out !== want.epoch_out)
                    $error("epoch_out exp %0d got %0d", want.epoch_out, got.epoch_out);
                if (got.year_out !== want.year_out)
                    $error("year_out exp %0d got %0d", want.year_out, got.year_out);
                if (got.month_out !== want.month_out)
                    $error("month_out exp %0d got %0d", want.month_out, got.month_out);
                if (got.day_out !== want.day_out)
                    $error("day_out exp %0d got %0d", want.day_out, got.day_out);
                if (got.hour_out !== want.hour_out)
                    $error("hour_out exp %0d got %0d", want.hour_out, got.hour_out);
                if (got.minute_out !== want.minute_out)
                    $error("minute_out exp %0d got %0d", want.minute_out, got.minute_out);
                if (got.second_out !== want.second_out)
                    $error("second_out exp %0d got %0d", want.second_out, got.second_out);
                if (got.weekday !== want.weekday)
                    $error("weekday exp %0d got %0d", want.weekday, got.weekday);
                if (got.out_of_range !== want.out_of_range)
                    $error("out_of_range exp %0d got %0d", want.out_of_range,
                        got.out_of_range);
                if (got !== want)
                    mismatches++;
            end
        end
    end

    // Main sequence.
    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_epoch_edges();
        test_calendar_edges();
        test_random_mix();
        in_ch.valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

`default_nettype wire
